### rtl/agc_pkg.sv
// Shared types, constants and segment tables for the AGC signal strength block.
// Used by every module and interface of the block; depends on nothing.

package agc_pkg;

    // Field and register widths
    localparam int READ_W = 10;
    localparam int PCT_W  = 7;
    localparam int MODE_W = 7;

    localparam logic [MODE_W-1:0] MODE_RESET = 7'd33;
    localparam int MODE_IF_BIT = 0;
    localparam int MODE_RF_BIT = 5;

    // Pipeline organization: six stages produce the gains, the seventh is the output register.
    localparam int GAIN_STAGES = 6;
    localparam int PIPE_DEPTH  = GAIN_STAGES + 1;
    localparam int SCALE_STAGES = 3;
    localparam int SCALE_DELAY  = GAIN_STAGES - SCALE_STAGES;

    typedef logic [GAIN_STAGES-1:0] stage_load_t;

    // Interpolation datapath widths
    localparam int GAIN_W = 8;
    localparam int COEF_W = 17;
    localparam int DIFF_W = READ_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int TERM_FULL_W = COEF_W + PROD_W;
    localparam int TERM_W = 25;
    localparam int SUM_W  = TERM_W + 2;
    localparam int ABS_W  = 25;

    // Quotient by 100000 as a multiply by the rounded-up reciprocal of 2^41.
    localparam int RECIP_W = 25;
    localparam logic [RECIP_W-1:0] QUOT_RECIP = 25'd21990233;
    localparam int QUOT_SHIFT  = 41;
    localparam int QUOT_W      = 9;
    localparam int QUOT_PROD_W = ABS_W + RECIP_W;

    // IF-only scaling: 100 * (reading - 50) / 1150, folded into one reciprocal of 2^27.
    localparam logic [DIFF_W-1:0] IF_SPAN_LO = 11'd50;
    localparam int SCALE_RECIP_W = 24;
    localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 24'd11671200;
    localparam int SCALE_SHIFT  = 27;
    localparam int SCALE_PROD_W = READ_W + SCALE_RECIP_W;

    // Percent values
    localparam logic [PCT_W-1:0] PCT_DEFAULT = 7'd80;
    localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0] PCT_NONE    = 7'd0;
    localparam logic [PCT_W-1:0] IF_PCT_MIN  = 7'd1;
    localparam logic [PCT_W-1:0] IF_PCT_MAX  = 7'd99;

    // RF level arithmetic, all 8-bit two's complement
    localparam logic signed [GAIN_W-1:0] RF_BASE   = -8'sd18;
    localparam logic signed [GAIN_W-1:0] LEVEL_MAX = -8'sd30;
    localparam logic signed [GAIN_W-1:0] LEVEL_MIN = -8'sd80;

    // Segment end points and the gains that apply beyond them
    localparam logic [READ_W-1:0] IF_LOW_END  = 10'd288;
    localparam logic [READ_W-1:0] IF_HIGH_END = 10'd965;
    localparam logic [READ_W-1:0] RF_LOW_END  = 10'd38;
    localparam logic [READ_W-1:0] RF_HIGH_END = 10'd232;
    localparam logic signed [GAIN_W-1:0] IF_LOW_GAIN  = 8'sd0;
    localparam logic signed [GAIN_W-1:0] IF_HIGH_GAIN = 8'sd26;
    localparam logic signed [GAIN_W-1:0] RF_LOW_GAIN  = -8'sd2;
    localparam logic signed [GAIN_W-1:0] RF_HIGH_GAIN = 8'sd43;

    localparam int IF_SEG_N = 4;
    localparam int RF_SEG_N = 6;
    localparam int IF_IDX_W = 2;
    localparam int RF_IDX_W = 3;

    // One quadratic segment over (x1, x3]
    typedef struct packed {
        logic [READ_W-1:0]        x1;
        logic [READ_W-1:0]        x2;
        logic [READ_W-1:0]        x3;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } seg_t;

    typedef struct packed {
        logic                     use_end;
        logic signed [GAIN_W-1:0] end_gain;
    } gain_ctl_t;

    function automatic seg_t if_seg(input logic [IF_IDX_W-1:0] idx);
        seg_t s;
        case (idx)
            2'd0:    s = '{x1: 10'd288, x2: 10'd375, x3: 10'd472,
                           a: 17'sd0,   b: -17'sd101,  c: 17'sd90};
            2'd1:    s = '{x1: 10'd472, x2: 10'd537, x3: 10'd640,
                           a: 17'sd146, b: -17'sd291,  c: 17'sd133};
            2'd2:    s = '{x1: 10'd640, x2: 10'd689, x3: 10'd710,
                           a: 17'sd671, b: -17'sd2332, c: 17'sd1667};
            default: s = '{x1: 10'd710, x2: 10'd857, x3: 10'd965,
                           a: 17'sd65,  b: -17'sd161,  c: 17'sd94};
        endcase
        return s;
    endfunction

    function automatic seg_t rf_seg(input logic [RF_IDX_W-1:0] idx);
        seg_t s;
        case (idx)
            3'd0:    s = '{x1: 10'd38,  x2: 10'd50,  x3: 10'd62,
                           a: -17'sd724,  b: -17'sd3571,  c: 17'sd3521};
            3'd1:    s = '{x1: 10'd62,  x2: 10'd79,  x3: 10'd100,
                           a: 17'sd1518,  b: -17'sd4187,  c: 17'sd2546};
            3'd2:    s = '{x1: 10'd100, x2: 10'd116, x3: 10'd131,
                           a: 17'sd3947,  b: -17'sd9375,  c: 17'sd5442};
            3'd3:    s = '{x1: 10'd131, x2: 10'd140, x3: 10'd147,
                           a: 17'sd19471, b: -17'sd47990, c: 17'sd28551};
            3'd4:    s = '{x1: 10'd147, x2: 10'd155, x3: 10'd172,
                           a: 17'sd16976, b: -17'sd27750, c: 17'sd9973};
            default: s = '{x1: 10'd172, x2: 10'd205, x3: 10'd232,
                           a: 17'sd2092,  b: -17'sd4704,  c: 17'sd2622};
        endcase
        return s;
    endfunction

endpackage

### rtl/agc_in_if.sv
// Input channel: one item carries an RF RSSI reading and an IF AGC reading.
// Depends on agc_pkg.

interface agc_in_if
    import agc_pkg::*;
    ();

    logic              valid;
    logic              ready;
    logic [READ_W-1:0] rf_reading;
    logic [READ_W-1:0] if_reading;

    modport source (output valid, output rf_reading, output if_reading, input ready);
    modport sink   (input valid, input rf_reading, input if_reading, output ready);

endinterface

### rtl/agc_out_if.sv
// Output channel: one item carries the signal strength percentage.
// Depends on agc_pkg.

interface agc_out_if
    import agc_pkg::*;
    ();

    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] signal_percent;

    modport source (output valid, output signal_percent, input ready);
    modport sink   (input valid, input signal_percent, output ready);

endinterface

### rtl/agc_seg_lookup.sv
// Segment selection for one reading: picks the quadratic segment that covers it
// and flags readings beyond the end points. Depends on agc_pkg.

module agc_seg_lookup
    import agc_pkg::*;
(
    input  logic [READ_W-1:0] reading,
    input  logic              is_rf,
    output seg_t              seg,
    output gain_ctl_t         ctl
);

    logic [IF_IDX_W-1:0] if_idx;
    logic [RF_IDX_W-1:0] rf_idx;

    // The first segment whose upper end is at or above the reading wins.
    always_comb
    begin
        seg_t s;
        if_idx = IF_IDX_W'(IF_SEG_N - 1);
        for (int k = IF_SEG_N - 1; k >= 0; k--)
        begin
            s = if_seg(IF_IDX_W'(k));
            if (reading <= s.x3)
            begin
                if_idx = IF_IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        seg_t s;
        rf_idx = RF_IDX_W'(RF_SEG_N - 1);
        for (int k = RF_SEG_N - 1; k >= 0; k--)
        begin
            s = rf_seg(RF_IDX_W'(k));
            if (reading <= s.x3)
            begin
                rf_idx = RF_IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        if (is_rf)
        begin
            seg          = rf_seg(rf_idx);
            ctl.use_end  = (reading <= RF_LOW_END) || (reading > RF_HIGH_END);
            ctl.end_gain = (reading <= RF_LOW_END) ? RF_LOW_GAIN : RF_HIGH_GAIN;
        end
        else
        begin
            seg          = if_seg(if_idx);
            ctl.use_end  = (reading <= IF_LOW_END) || (reading > IF_HIGH_END);
            ctl.end_gain = (reading <= IF_LOW_END) ? IF_LOW_GAIN : IF_HIGH_GAIN;
        end
    end

endmodule

### rtl/agc_gain_pipe.sv
// Six-stage gain pipeline for one reading: segment pick, difference products,
// coefficient products, sum and magnitude, quotient by 100000, final gain.
// Depends on agc_pkg and agc_seg_lookup.

module agc_gain_pipe
    import agc_pkg::*;
(
    input  logic                     clk,
    input  logic                     is_rf,
    input  logic [READ_W-1:0]        reading,
    input  stage_load_t              load,
    output logic signed [GAIN_W-1:0] gain
);

    seg_t      seg_lk;
    gain_ctl_t ctl_lk;

    // Stage 1
    logic [READ_W-1:0] reading_s1_reg;
    seg_t              seg_s1_reg;
    gain_ctl_t         ctl_s1_reg;

    // Stage 2
    logic signed [DIFF_W-1:0] d1, d2, d3;
    logic signed [PROD_W-1:0] pa_next, pb_next, pc_next;
    logic signed [PROD_W-1:0] pa_s2_reg, pb_s2_reg, pc_s2_reg;
    logic signed [COEF_W-1:0] a_s2_reg, b_s2_reg, c_s2_reg;
    gain_ctl_t                ctl_s2_reg;

    // Stage 3
    logic signed [TERM_FULL_W-1:0] ta_full, tb_full, tc_full;
    logic signed [TERM_W-1:0]      ta_s3_reg, tb_s3_reg, tc_s3_reg;
    gain_ctl_t                     ctl_s3_reg;

    // Stage 4
    logic signed [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0]        abs_full;
    logic [ABS_W-1:0]        abs_s4_reg;
    logic                    neg_s4_reg;
    gain_ctl_t               ctl_s4_reg;

    // Stage 5
    logic [QUOT_PROD_W-1:0] quot_prod;
    logic [QUOT_W-1:0]      quot_s5_reg;
    logic                   neg_s5_reg;
    gain_ctl_t              ctl_s5_reg;

    // Stage 6
    logic [GAIN_W-1:0]        quot_low;
    logic signed [GAIN_W-1:0] gain_next;
    logic signed [GAIN_W-1:0] gain_s6_reg;

    agc_seg_lookup u_lookup (
        .reading (reading),
        .is_rf   (is_rf),
        .seg     (seg_lk),
        .ctl     (ctl_lk)
    );

    always_comb
    begin
        d1 = $signed({1'b0, reading_s1_reg}) - $signed({1'b0, seg_s1_reg.x1});
        d2 = $signed({1'b0, reading_s1_reg}) - $signed({1'b0, seg_s1_reg.x2});
        d3 = $signed({1'b0, reading_s1_reg}) - $signed({1'b0, seg_s1_reg.x3});
        pa_next = d2 * d3;
        pb_next = d1 * d3;
        pc_next = d1 * d2;
    end

    // Inside a segment every term stays far below the kept width.
    always_comb
    begin
        ta_full = a_s2_reg * pa_s2_reg;
        tb_full = b_s2_reg * pb_s2_reg;
        tc_full = c_s2_reg * pc_s2_reg;
    end

    always_comb
    begin
        sum_next = SUM_W'(ta_s3_reg) + SUM_W'(tb_s3_reg) + SUM_W'(tc_s3_reg);
        abs_full = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
    end

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign quot_prod = QUOT_PROD_W'(abs_s4_reg) * QUOT_PROD_W'(QUOT_RECIP);

    always_comb
    begin
        quot_low = quot_s5_reg[GAIN_W-1:0];
        if (ctl_s5_reg.use_end)
        begin
            gain_next = ctl_s5_reg.end_gain;
        end
        else if (neg_s5_reg)
        begin
            gain_next = $signed(GAIN_W'(0) - quot_low);
        end
        else
        begin
            gain_next = $signed(quot_low);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            reading_s1_reg <= reading;
            seg_s1_reg     <= seg_lk;
            ctl_s1_reg     <= ctl_lk;
        end
        if (load[1])
        begin
            pa_s2_reg  <= pa_next;
            pb_s2_reg  <= pb_next;
            pc_s2_reg  <= pc_next;
            a_s2_reg   <= seg_s1_reg.a;
            b_s2_reg   <= seg_s1_reg.b;
            c_s2_reg   <= seg_s1_reg.c;
            ctl_s2_reg <= ctl_s1_reg;
        end
        if (load[2])
        begin
            ta_s3_reg  <= ta_full[TERM_W-1:0];
            tb_s3_reg  <= tb_full[TERM_W-1:0];
            tc_s3_reg  <= tc_full[TERM_W-1:0];
            ctl_s3_reg <= ctl_s2_reg;
        end
        if (load[3])
        begin
            abs_s4_reg <= abs_full[ABS_W-1:0];
            neg_s4_reg <= sum_next[SUM_W-1];
            ctl_s4_reg <= ctl_s3_reg;
        end
        if (load[4])
        begin
            quot_s5_reg <= quot_prod[QUOT_SHIFT+QUOT_W-1:QUOT_SHIFT];
            neg_s5_reg  <= neg_s4_reg;
            ctl_s5_reg  <= ctl_s4_reg;
        end
        if (load[5])
        begin
            gain_s6_reg <= gain_next;
        end
    end

    assign gain = gain_s6_reg;

endmodule

### rtl/agc_if_scale.sv
// Linear IF-only percentage over the 50..1200 span, limited to 1..99, delayed to
// line up with the gain pipelines. Depends on agc_pkg.

module agc_if_scale
    import agc_pkg::*;
(
    input  logic              clk,
    input  logic [READ_W-1:0] if_reading,
    input  stage_load_t       load,
    output logic [PCT_W-1:0]  scaled
);

    logic [DIFF_W-1:0]       offset;
    logic [DIFF_W-1:0]       mag_full;
    logic [READ_W-1:0]       mag_s1_reg;
    logic                    neg_s1_reg;
    logic [SCALE_PROD_W-1:0] scale_prod;
    logic [PCT_W-1:0]        quot_s2_reg;
    logic                    neg_s2_reg;
    logic [PCT_W-1:0]        res_next;
    logic [PCT_W-1:0]        res_s3_reg;
    logic [PCT_W-1:0]        res_dly_reg [SCALE_DELAY];

    always_comb
    begin
        offset   = {1'b0, if_reading} - IF_SPAN_LO;
        mag_full = offset[DIFF_W-1] ? (DIFF_W'(0) - offset) : offset;
    end

    assign scale_prod = SCALE_PROD_W'(mag_s1_reg) * SCALE_PROD_W'(SCALE_RECIP);

    // A nonzero negative quotient wraps to 252..255 in the byte and is limited to 99.
    always_comb
    begin
        if (quot_s2_reg == PCT_NONE)
        begin
            res_next = IF_PCT_MIN;
        end
        else if (neg_s2_reg || (quot_s2_reg >= PCT_FULL))
        begin
            res_next = IF_PCT_MAX;
        end
        else
        begin
            res_next = quot_s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            mag_s1_reg <= mag_full[READ_W-1:0];
            neg_s1_reg <= offset[DIFF_W-1];
        end
        if (load[1])
        begin
            quot_s2_reg <= scale_prod[SCALE_SHIFT+PCT_W-1:SCALE_SHIFT];
            neg_s2_reg  <= neg_s1_reg;
        end
        if (load[2])
        begin
            res_s3_reg <= res_next;
        end
        for (int i = 0; i < SCALE_DELAY; i++)
        begin
            if (load[SCALE_STAGES+i])
            begin
                res_dly_reg[i] <= (i == 0) ? res_s3_reg : res_dly_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    assign scaled = res_dly_reg[SCALE_DELAY-1];

endmodule

### rtl/agc_reading_to_signal_percent.sv
// Top level of the AGC signal strength estimator: mode register, pipeline valid
// and stall control, gain combination and output register.
// Depends on agc_pkg, agc_in_if, agc_out_if, agc_gain_pipe and agc_if_scale.
//
//   Channel    Dir  Handshake       Payload
//   reading    in   valid / ready   rf_reading[9:0], if_reading[9:0]
//   strength   out  valid / ready   signal_percent[6:0]
//   cfg        in   cfg_we          cfg_wdata[6:0] = mode_flags
//
// One item is taken per cycle unless a stalled output has filled every stage; each result
// passes the gain pipeline stages and then the output register. Each stage loads whenever it is
// empty or its successor loads, so bubbles close up and a stalled output still lets
// items enter until every stage is full. Reset clears all valid bits and sets
// mode_flags to 33; no items are in flight after reset.

module agc_reading_to_signal_percent
    import agc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [MODE_W-1:0] cfg_wdata,
    agc_in_if.sink            reading,
    agc_out_if.source         strength
);

    logic [MODE_W-1:0]     mode_flags_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] load;

    logic signed [GAIN_W-1:0] if_gain;
    logic signed [GAIN_W-1:0] rf_gain;
    logic [PCT_W-1:0]         if_scaled;

    logic [GAIN_W-1:0] gain_sum;
    logic [GAIN_W-1:0] level;
    logic [GAIN_W-1:0] level_ofs;
    logic [PCT_W-1:0]  pct_both;
    logic [PCT_W-1:0]  signal_percent_next;
    logic [PCT_W-1:0]  signal_percent_reg;
    logic              if_en;
    logic              rf_en;

    always_comb
    begin
        load[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || strength.ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        valid_next[0] = load[0] ? reading.valid : valid_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign reading.ready = load[0];

    agc_gain_pipe u_if_gain (
        .clk     (clk),
        .is_rf   (1'b0),
        .reading (reading.if_reading),
        .load    (load[GAIN_STAGES-1:0]),
        .gain    (if_gain)
    );

    agc_gain_pipe u_rf_gain (
        .clk     (clk),
        .is_rf   (1'b1),
        .reading (reading.rf_reading),
        .load    (load[GAIN_STAGES-1:0]),
        .gain    (rf_gain)
    );

    agc_if_scale u_if_scale (
        .clk        (clk),
        .if_reading (reading.if_reading),
        .load       (load[GAIN_STAGES-1:0]),
        .scaled     (if_scaled)
    );

    // The user must change the mode register only while no item is in flight; the block does not enforce it.
    assign if_en = mode_flags_reg[MODE_IF_BIT];
    assign rf_en = mode_flags_reg[MODE_RF_BIT];

    // Level arithmetic wraps in eight bits; inside the open range the percent
    // is exactly twice the distance below the upper clamp.
    always_comb
    begin
        gain_sum  = if_gain + rf_gain;
        level     = RF_BASE - gain_sum;
        level_ofs = level - LEVEL_MIN;
        if ($signed(level) >= LEVEL_MAX)
        begin
            pct_both = PCT_NONE;
        end
        else if ($signed(level) <= LEVEL_MIN)
        begin
            pct_both = PCT_FULL;
        end
        else
        begin
            pct_both = PCT_FULL - {level_ofs[PCT_W-2:0], 1'b0};
        end

        if (if_en && rf_en)
        begin
            signal_percent_next = pct_both;
        end
        else if (if_en)
        begin
            signal_percent_next = if_scaled;
        end
        else
        begin
            signal_percent_next = PCT_DEFAULT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_flags_reg <= MODE_RESET;
            valid_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_flags_reg <= cfg_wdata;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[PIPE_DEPTH-1])
        begin
            signal_percent_reg <= signal_percent_next;
        end
    end

    assign strength.valid          = valid_reg[PIPE_DEPTH-1];
    assign strength.signal_percent = signal_percent_reg;

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !reading.ready |-> (&valid_reg)
    ) else $error("input held off while the pipeline has an empty stage");

    a_percent_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        strength.valid |-> (signal_percent_reg <= PCT_FULL)
    ) else $error("signal percent above 100");

    a_default_without_if: assert property (
        @(posedge clk) disable iff (!rst_n)
        (strength.valid && !mode_flags_reg[MODE_IF_BIT])
            |-> (signal_percent_reg == PCT_DEFAULT)
    ) else $error("result differs from the default with IF gain disabled");

    a_if_only_limits: assert property (
        @(posedge clk) disable iff (!rst_n)
        (strength.valid && mode_flags_reg[MODE_IF_BIT] && !mode_flags_reg[MODE_RF_BIT])
            |-> ((signal_percent_reg >= IF_PCT_MIN) && (signal_percent_reg <= IF_PCT_MAX))
    ) else $error("IF-only result outside 1..99");
`endif

endmodule

### test/agc_strength_checker.sv
`timescale 1ns / 100ps
// Checker for the AGC signal strength block: it watches the reading and strength channels
// and the mode register port, predicts each percentage and compares. Depends on agc_pkg,
// agc_in_if and agc_out_if.

module agc_strength_checker
    import agc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [MODE_W-1:0] cfg_wdata,
    agc_in_if                 reading,
    agc_out_if                strength,
    output int                mismatches,
    output int                pending,
    output int                checked
);

    localparam int QUOT_DIV = 100000;

    // Curve knots: segment k spans (KNOT[k], KNOT[k+1]] with its middle point MID[k].
    localparam int IF_KNOT [5] = '{288, 472, 640, 710, 965};
    localparam int IF_MID  [4] = '{375, 537, 689, 857};
    localparam int IF_CA   [4] = '{0, 146, 671, 65};
    localparam int IF_CB   [4] = '{-101, -291, -2332, -161};
    localparam int IF_CC   [4] = '{90, 133, 1667, 94};

    localparam int RF_KNOT [7] = '{38, 62, 100, 131, 147, 172, 232};
    localparam int RF_MID  [6] = '{50, 79, 116, 140, 155, 205};
    localparam int RF_CA   [6] = '{-724, 1518, 3947, 19471, 16976, 2092};
    localparam int RF_CB   [6] = '{-3571, -4187, -9375, -47990, -27750, -4704};
    localparam int RF_CC   [6] = '{3521, 2546, 5442, 28551, 9973, 2622};

    localparam logic signed [7:0] IF_FLOOR_DB = 8'sd0;
    localparam logic signed [7:0] IF_CEIL_DB  = 8'sd26;
    localparam logic signed [7:0] RF_FLOOR_DB = -8'sd2;
    localparam logic signed [7:0] RF_CEIL_DB  = 8'sd43;
    localparam logic signed [7:0] LEVEL_BASE  = -8'sd18;
    localparam int LEVEL_TOP    = -30;
    localparam int LEVEL_BOTTOM = -80;
    localparam int SPAN_LO      = 50;
    localparam int SPAN_HI      = 1200;
    localparam logic [PCT_W-1:0] FIXED_PCT = 7'd80;

    logic [MODE_W-1:0] mode;
    logic [PCT_W-1:0]  expected_pct[$];

    function automatic logic signed [7:0] lagrange_db(input int v, input int x1, input int x2,
                                                      input int x3, input int a, input int b,
                                                      input int c);
        int acc;
        acc = a * (v - x2) * (v - x3) + b * (v - x1) * (v - x3) + c * (v - x1) * (v - x2);
        acc = acc / QUOT_DIV;
        return acc[7:0];
    endfunction

    function automatic logic signed [7:0] if_gain_db(input int v);
        if (v <= IF_KNOT[0])
            return IF_FLOOR_DB;
        for (int k = 0; k < 4; k++)
            if (v <= IF_KNOT[k+1])
                return lagrange_db(v, IF_KNOT[k], IF_MID[k], IF_KNOT[k+1],
                                   IF_CA[k], IF_CB[k], IF_CC[k]);
        return IF_CEIL_DB;
    endfunction

    function automatic logic signed [7:0] rf_gain_db(input int v);
        if (v <= RF_KNOT[0])
            return RF_FLOOR_DB;
        for (int k = 0; k < 6; k++)
            if (v <= RF_KNOT[k+1])
                return lagrange_db(v, RF_KNOT[k], RF_MID[k], RF_KNOT[k+1],
                                   RF_CA[k], RF_CB[k], RF_CC[k]);
        return RF_CEIL_DB;
    endfunction

    function automatic logic [PCT_W-1:0] predict_percent(input logic [MODE_W-1:0] flags,
                                                         input logic [READ_W-1:0] rf,
                                                         input logic [READ_W-1:0] ifr);
        logic signed [7:0] gain_sum;
        logic signed [7:0] level;
        int pct;
        int q;
        int r;
        if (flags[MODE_IF_BIT] && flags[MODE_RF_BIT])
        begin
            // Gains, their sum and the level all wrap as 8-bit values.
            gain_sum = if_gain_db(int'(ifr)) + rf_gain_db(int'(rf));
            level = LEVEL_BASE - gain_sum;
            if (level >= LEVEL_TOP)
                pct = 100;
            else if (level <= LEVEL_BOTTOM)
                pct = 0;
            else
                pct = (100 * (int'(level) - LEVEL_BOTTOM)) / (LEVEL_TOP - LEVEL_BOTTOM);
            return PCT_W'(100 - pct);
        end
        if (flags[MODE_IF_BIT])
        begin
            // A reading below the span goes negative and wraps to a large byte.
            q = (100 * (int'(ifr) - SPAN_LO)) / (SPAN_HI - SPAN_LO);
            r = q & 255;
            if (r >= 100)
                r = 99;
            else if (r == 0)
                r = 1;
            return PCT_W'(r);
        end
        return FIXED_PCT;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [PCT_W-1:0] want;
        if (!rst_n)
        begin
            mode <= MODE_RESET;
            expected_pct.delete();
            mismatches <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (cfg_we)
                mode <= cfg_wdata;
            if (strength.valid && strength.ready)
            begin
                if (expected_pct.size() == 0)
                begin
                    $error("signal_percent: unexpected item %0d", strength.signal_percent);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_pct.pop_front();
                    checked <= checked + 1;
                    if (strength.signal_percent !== want)
                    begin
                        $error("signal_percent: expected %0d, actual %0d",
                               want, strength.signal_percent);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (reading.valid && reading.ready)
                expected_pct.push_back(predict_percent(mode, reading.rf_reading,
                                                       reading.if_reading));
            pending <= expected_pct.size();
        end
    end

endmodule

### test/agc_reading_to_signal_percent_test.sv
`timescale 1ns / 100ps
// Testbench top for agc_reading_to_signal_percent: clock, reset, mode writes, reading
// stimulus and output back-pressure. Depends on agc_pkg, the channel interfaces and the checker.

module agc_reading_to_signal_percent_test;
    import agc_pkg::*;

    localparam logic [MODE_W-1:0] IF_ON   = MODE_W'(1 << MODE_IF_BIT);
    localparam logic [MODE_W-1:0] RF_ON   = MODE_W'(1 << MODE_RF_BIT);
    localparam logic [MODE_W-1:0] BOTH_ON = IF_ON | RF_ON;
    localparam logic [MODE_W-1:0] ALL_ON  = '1;
    localparam logic [MODE_W-1:0] ALL_OFF = '0;
    localparam int IDLE_PCT   = 16;
    localparam int DRAIN_WAIT = PIPE_DEPTH + 5;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [MODE_W-1:0] cfg_wdata;
    bit                steady;
    int                mismatches;
    int                pending;
    int                checked;
    int                sent;
    int                settings;

    agc_in_if  reading ();
    agc_out_if strength ();

    agc_reading_to_signal_percent dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .reading   (reading),
        .strength  (strength)
    );

    agc_strength_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .reading    (reading),
        .strength   (strength),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        strength.ready = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        strength.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_reading(input logic [READ_W-1:0] rf, input logic [READ_W-1:0] ifr);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            reading.valid <= 1'b0;
            @(posedge clk);
        end
        reading.valid <= 1'b1;
        reading.rf_reading <= rf;
        reading.if_reading <= ifr;
        @(posedge clk);
        while (!reading.ready)
            @(posedge clk);
        sent++;
    endtask

    // Drops valid and waits until every percentage of the phase has come back.
    task automatic drain;
        reading.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] flags);
        cfg_we <= 1'b1;
        cfg_wdata <= flags;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Half of the readings fall where the curves bend, the rest anywhere.
    function automatic logic [READ_W-1:0] pick_reading(input int lo, input int hi);
        if ($urandom_range(1) == 0)
            return READ_W'($urandom_range(1023));
        return READ_W'($urandom_range(hi, lo));
    endfunction

    task automatic random_readings(input int count);
        for (int i = 0; i < count; i++)
            send_reading(pick_reading(30, 240), pick_reading(280, 975));
    endtask

    initial
    begin : stimulus
        logic [READ_W-1:0] corner_rf [15];
        logic [READ_W-1:0] corner_if [15];
        logic [READ_W-1:0] span_if [6];
        corner_rf = '{0, 1023, 38, 39, 232, 233, 131, 132, 147, 62, 100, 172, 140, 1023, 0};
        corner_if = '{0, 1023, 288, 289, 965, 966, 640, 641, 710, 472, 500, 800, 600, 0, 1023};
        span_if = '{0, 49, 50, 61, 62, 1023};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        steady = 1'b0;
        sent = 0;
        settings = 1;
        reading.valid = 1'b0;
        reading.rf_reading = '0;
        reading.if_reading = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value enables both gains: curve ends and both clamp ends.
        foreach (corner_rf[i])
            send_reading(corner_rf[i], corner_if[i]);
        drain();

        // IF only: the linear span, its low wrap and the clamps, with the RF input ignored.
        write_mode(IF_ON);
        foreach (span_if[i])
            send_reading(READ_W'($urandom_range(1023)), span_if[i]);
        random_readings(250);
        drain();

        write_mode(ALL_ON);
        random_readings(300);
        drain();

        write_mode(ALL_OFF);
        random_readings(50);
        drain();

        write_mode(RF_ON);
        random_readings(60);
        drain();

        // Only the ignored bits set, then IF with all the low bits.
        write_mode(~BOTH_ON);
        random_readings(40);
        drain();

        write_mode(MODE_W'(5'h1F));
        random_readings(100);
        drain();

        // Back-to-back stretch with no idling on either side.
        write_mode(BOTH_ON);
        steady = 1'b1;
        random_readings(350);
        drain();
        steady = 1'b0;

        write_mode(BOTH_ON | MODE_W'($urandom_range(127)));
        random_readings(100);
        drain();

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("%0d reading pairs sent through %0d mode settings, %0d percentages checked",
                 sent, settings, checked);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
